/* hw/rtl/mbc_pkg.sv */
// ----------------------------------------------------------------------------
// Mandelbrot banded colour pixel - shared package
// Widths, register map, configuration bundle, controller states and the
// command and status words passed between controller and datapath.
// ----------------------------------------------------------------------------
package mbc_pkg;

  // Field and format widths
  localparam int PixBits      = 12;             // pixel column / row
  localparam int CoordBits    = 13;             // signed pixel offset
  localparam int FracBits     = 28;             // fraction bits of Q4.FracBits
  localparam int StepBits     = 11;             // iteration index
  localparam int StepRegBits  = 31;             // x_step / y_step
  localparam int MaxStepsBits = 10;             // iteration limit register
  localparam int ColBits      = 8;              // colour channel

  // Configuration port
  localparam int CfgIdxBits   = 3;
  localparam int CfgDataBits  = 31;

  // Register reset values
  localparam logic [StepRegBits-1:0]  XStepRst    = StepRegBits'(524288);
  localparam logic [StepRegBits-1:0]  YStepRst    = StepRegBits'(524288);
  localparam logic [MaxStepsBits-1:0] MaxStepsRst = MaxStepsBits'(100);

  // Register index map
  typedef enum logic [CfgIdxBits-1:0] {
    REG_X_STEP,
    REG_Y_STEP,
    REG_SHIFT_X,
    REG_SHIFT_Y,
    REG_MAX_STEPS
  } mbc_reg_e;

  // Current register contents
  typedef struct packed {
    logic        [StepRegBits-1:0]  x_step;
    logic        [StepRegBits-1:0]  y_step;
    logic signed [CoordBits-1:0]    shift_x;
    logic signed [CoordBits-1:0]    shift_y;
    logic        [MaxStepsBits-1:0] iter_limit;
  } mbc_cfg_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ITER,
    S_BAND,
    S_OUT
  } mbc_state_e;

  // Controller to datapath
  typedef struct packed {
    logic cap_pixel;   // latch the accepted pixel
    logic load_c;      // form c, clear the orbit
    logic iter;        // run one orbit step
    logic band;        // form band values in tenths
    logic load_out;    // fill the output register
  } mbc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic iter_done;   // orbit escaped, settled or reached the limit this cycle
  } mbc_stat_t;

endpackage

/* hw/rtl/mbc_intf.sv */
// ----------------------------------------------------------------------------
// Mandelbrot banded colour pixel - channel interfaces
// Pixel input, colour result and configuration write channels, each a
// valid/ready channel with source and sink views.
// ----------------------------------------------------------------------------

// Pixel coordinate channel
interface mbc_pixel_if;
  logic                           valid;
  logic                           ready;
  logic [mbc_pkg::PixBits-1:0]    pixel_x;
  logic [mbc_pkg::PixBits-1:0]    pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// Colour result channel
interface mbc_result_if;
  logic                           valid;
  logic                           ready;
  logic [mbc_pkg::ColBits-1:0]    red;
  logic [mbc_pkg::ColBits-1:0]    green;
  logic [mbc_pkg::ColBits-1:0]    blue;
  logic                           escaped;
  logic [mbc_pkg::StepBits-1:0]   iterations;

  modport source (output valid, output red, output green, output blue,
                  output escaped, output iterations, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input escaped, input iterations, output ready);
endinterface

// Configuration write channel
interface mbc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mbc_pkg::CfgIdxBits-1:0]  index;
  logic [mbc_pkg::CfgDataBits-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/mandelbrot_banded_color_pixel.sv */
// ----------------------------------------------------------------------------
// Mandelbrot banded colour pixel - top level
// Maps a pixel to c in Q4.28 and colours it by its escape-time band.
// ----------------------------------------------------------------------------
// One pixel is worked at a time. After the pixel word is accepted the block
// scales it to c, then runs one orbit step per cycle in the complex-square
// unit, plus a closing step for the radius test of the last orbit step
// unless a component leaves the range at once, then colours the pixel in a
// band state and an output state; the next pixel word is taken once the
// block is idle again. The result sits in an output register, so the next
// pixel word is accepted while the previous colour waits to be taken.
// Configuration writes are always taken; make them only while no pixel is
// in flight.
// ----------------------------------------------------------------------------
module mandelbrot_banded_color_pixel (
  input  logic          clk_i,
  input  logic          rst_ni,
  mbc_cfg_if.sink       cfg_i,
  mbc_pixel_if.sink     pixel_i,
  mbc_result_if.source  result_o
);

  mbc_pkg::mbc_cfg_t  regs;
  mbc_pkg::mbc_cmd_t  cmd;
  mbc_pkg::mbc_stat_t stat;

  // Register file
  mbc_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  // Sequencer
  mbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pixel_i.valid),
    .pix_ready_o (pixel_i.ready),
    .res_valid_o (result_o.valid),
    .res_ready_i (result_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Arithmetic and output register
  mbc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (regs),
    .pix_x_i      (pixel_i.pixel_x),
    .pix_y_i      (pixel_i.pixel_y),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .red_o        (result_o.red),
    .green_o      (result_o.green),
    .blue_o       (result_o.blue),
    .escaped_o    (result_o.escaped),
    .iterations_o (result_o.iterations)
  );

endmodule

/* hw/rtl/mbc_cfg.sv */
// ----------------------------------------------------------------------------
// Mandelbrot banded colour pixel - configuration registers
// Holds the step sizes, pixel offsets and iteration limit; every write
// word is taken at once.
// ----------------------------------------------------------------------------
module mbc_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  mbc_cfg_if.sink           cfg_i,
  output mbc_pkg::mbc_cfg_t regs_o
);

  mbc_pkg::mbc_cfg_t regs_q;

  assign cfg_i.ready = 1'b1;
  assign regs_o      = regs_q;

  // Write the addressed register, drop writes beyond the map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.x_step     <= mbc_pkg::XStepRst;
      regs_q.y_step     <= mbc_pkg::YStepRst;
      regs_q.shift_x    <= '0;
      regs_q.shift_y    <= '0;
      regs_q.iter_limit <= mbc_pkg::MaxStepsRst;
    end else if (cfg_i.valid) begin
      case (mbc_pkg::mbc_reg_e'(cfg_i.index))
        mbc_pkg::REG_X_STEP: begin
          regs_q.x_step <= cfg_i.data[mbc_pkg::StepRegBits-1:0];
        end
        mbc_pkg::REG_Y_STEP: begin
          regs_q.y_step <= cfg_i.data[mbc_pkg::StepRegBits-1:0];
        end
        mbc_pkg::REG_SHIFT_X: begin
          regs_q.shift_x <= $signed(cfg_i.data[mbc_pkg::CoordBits-1:0]);
        end
        mbc_pkg::REG_SHIFT_Y: begin
          regs_q.shift_y <= $signed(cfg_i.data[mbc_pkg::CoordBits-1:0]);
        end
        mbc_pkg::REG_MAX_STEPS: begin
          regs_q.iter_limit <= cfg_i.data[mbc_pkg::MaxStepsBits-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* hw/rtl/mbc_ctrl.sv */
// ----------------------------------------------------------------------------
// Mandelbrot banded colour pixel - controller
// Sequences accept, coordinate set-up, orbit steps and colouring, and owns
// the valid flag of the output register.
// ----------------------------------------------------------------------------
module mbc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pix_valid_i,
  output logic               pix_ready_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  input  mbc_pkg::mbc_stat_t stat_i,
  output mbc_pkg::mbc_cmd_t  cmd_o
);

  mbc_pkg::mbc_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                out_free;

  assign res_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || res_ready_i;

  // State and output flag registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mbc_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    pix_ready_o = 1'b0;
    case (state_q)
      mbc_pkg::S_IDLE: begin
        pix_ready_o = 1'b1;
        if (pix_valid_i) begin
          cmd_o.cap_pixel = 1'b1;
          state_d         = mbc_pkg::S_LOAD;
        end
      end
      mbc_pkg::S_LOAD: begin
        cmd_o.load_c = 1'b1;
        state_d      = mbc_pkg::S_ITER;
      end
      mbc_pkg::S_ITER: begin
        cmd_o.iter = 1'b1;
        if (stat_i.iter_done) begin
          state_d = mbc_pkg::S_BAND;
        end
      end
      mbc_pkg::S_BAND: begin
        cmd_o.band = 1'b1;
        state_d    = mbc_pkg::S_OUT;
      end
      mbc_pkg::S_OUT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = mbc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mbc_pkg::S_IDLE;
      end
    endcase

    // Set on a new result, clear once the word is taken
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Never overwrite a result that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || res_ready_i))
    else $error("output register overwritten while occupied");

  // An accepted pixel always moves on to coordinate set-up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_valid_i && pix_ready_o) |=> (state_q == mbc_pkg::S_LOAD))
    else $error("accepted pixel not followed by set-up");

  // A pending result leaves only through a handshake
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_q) |-> $past(res_ready_i))
    else $error("result dropped without handshake");

endmodule

/* hw/rtl/mbc_dp.sv */
// ----------------------------------------------------------------------------
// Mandelbrot banded colour pixel - datapath
// Coordinate scaling with saturation, the complex-square unit that runs one
// orbit step per cycle, band colouring and the output register.
// ----------------------------------------------------------------------------
module mbc_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mbc_pkg::mbc_cfg_t                   cfg_i,
  input  logic [mbc_pkg::PixBits-1:0]         pix_x_i,
  input  logic [mbc_pkg::PixBits-1:0]         pix_y_i,
  input  mbc_pkg::mbc_cmd_t                   cmd_i,
  output mbc_pkg::mbc_stat_t                  stat_o,
  output logic [mbc_pkg::ColBits-1:0]         red_o,
  output logic [mbc_pkg::ColBits-1:0]         green_o,
  output logic [mbc_pkg::ColBits-1:0]         blue_o,
  output logic                                escaped_o,
  output logic [mbc_pkg::StepBits-1:0]        iterations_o
);

  // Number formats
  localparam int OffBits  = mbc_pkg::CoordBits + 1;            // pixel minus shift
  localparam int ProdBits = OffBits + mbc_pkg::StepRegBits + 1;
  localparam int CBits    = mbc_pkg::FracBits + 4;             // c, Q4.F
  localparam int ZBits    = mbc_pkg::FracBits + 3;             // |z| <= 2
  localparam int MagBits  = mbc_pkg::FracBits + 2;
  localparam int SqBits   = 2 * MagBits;
  localparam int NBits    = mbc_pkg::FracBits + 6;             // unchecked z'
  localparam int StepBits = mbc_pkg::StepBits;
  localparam int ColBits  = mbc_pkg::ColBits;

  localparam logic signed [ProdBits-1:0] CHi =
    (ProdBits'(1) << (CBits - 1)) - ProdBits'(1);
  localparam logic signed [ProdBits-1:0] CLo = -CHi - ProdBits'(1);
  localparam logic signed [NBits-1:0]    ZLim = NBits'(1) << (mbc_pkg::FracBits + 1);
  localparam logic [SqBits:0]            EscTh =
    (SqBits + 1)'(1) << (2 * mbc_pkg::FracBits + 2);

  // Band colouring, values in tenths
  localparam int TBits      = 20;
  localparam int LvlBits    = 13;
  localparam int SlopeBits  = 8;
  localparam int TenthBits  = 12;
  localparam int RecipBits  = 25;
  localparam int DivMul     = 6554;     // 2^16 / 10, rounded up
  localparam int DivShift   = 16;
  localparam int BandLen    = 25;
  localparam logic signed [LvlBits-1:0]   LvlZero  = '0;
  localparam logic signed [LvlBits-1:0]   LvlMid   = LvlBits'(1600);
  localparam logic signed [LvlBits-1:0]   LvlTop   = LvlBits'(2550);
  localparam logic signed [SlopeBits-1:0] SlpNone  = '0;
  localparam logic signed [SlopeBits-1:0] SlpUp    = SlopeBits'(102);
  localparam logic signed [SlopeBits-1:0] SlpDown  = -SlopeBits'(102);
  localparam logic signed [SlopeBits-1:0] SlpGreen = -SlopeBits'(38);
  localparam logic signed [SlopeBits-1:0] SlpHalf  = -SlopeBits'(51);
  localparam logic signed [TBits-1:0]     ClampTenths = TBits'(2560);
  localparam logic [StepBits-1:0] Bnd1 = StepBits'(BandLen);
  localparam logic [StepBits-1:0] Bnd2 = StepBits'(2 * BandLen);
  localparam logic [StepBits-1:0] Bnd3 = StepBits'(3 * BandLen);
  localparam logic [StepBits-1:0] Bnd4 = StepBits'(4 * BandLen);
  localparam logic [StepBits-1:0] Bnd5 = StepBits'(5 * BandLen);
  localparam logic [StepBits-1:0] Bnd6 = StepBits'(6 * BandLen);
  localparam logic [StepBits-1:0] Bnd7 = StepBits'(7 * BandLen);
  localparam logic [StepBits-1:0] Bnd8 = StepBits'(8 * BandLen);

  function automatic logic signed [TBits-1:0] band_t(
    input logic signed [LvlBits-1:0]   base,
    input logic signed [SlopeBits-1:0] slope,
    input logic        [StepBits-1:0]  k
  );
    logic signed [TBits-1:0] prod;
    prod = TBits'(slope) * TBits'($signed({1'b0, k}));
    return prod + TBits'(base);
  endfunction

  // Tenths to channel: clamp, then divide by ten via reciprocal
  function automatic logic [ColBits-1:0] to_chan(input logic signed [TBits-1:0] t);
    logic [RecipBits-1:0] q;
    q = RecipBits'(t[TenthBits-1:0]) * RecipBits'(DivMul);
    if (t < 0) begin
      return '0;
    end else if (t >= ClampTenths) begin
      return '1;
    end
    return q[DivShift +: ColBits];
  endfunction

  // ---------------------------------------------------------------- pixel
  logic [mbc_pkg::PixBits-1:0] px_q, py_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_pixel) begin
      px_q <= pix_x_i;
      py_q <= pix_y_i;
    end
  end

  // Scale the offset pixel, saturate to Q4.F
  logic signed [OffBits-1:0]  off_x, off_y;
  logic signed [ProdBits-1:0] prod_x, prod_y;
  logic signed [CBits-1:0]    cx_d, cy_d;

  assign off_x  = $signed(OffBits'(px_q)) - OffBits'(cfg_i.shift_x);
  assign off_y  = $signed(OffBits'(py_q)) - OffBits'(cfg_i.shift_y);
  assign prod_x = off_x * $signed({1'b0, cfg_i.x_step});
  assign prod_y = off_y * $signed({1'b0, cfg_i.y_step});
  assign cx_d   = (prod_x > CHi) ? CBits'(CHi) :
                  (prod_x < CLo) ? CBits'(CLo) : CBits'(prod_x);
  assign cy_d   = (prod_y > CHi) ? CBits'(CHi) :
                  (prod_y < CLo) ? CBits'(CLo) : CBits'(prod_y);

  // ---------------------------------------------------------------- orbit
  logic signed [CBits-1:0]   cx_q, cy_q;
  logic signed [ZBits-1:0]   zx_q, zy_q, zpx_q, zpy_q;
  logic [StepBits-1:0]       n_q;
  logic                      fin_esc_q;
  logic [StepBits-1:0]       fin_n_q;

  logic [MagBits-1:0]        mx, my;
  logic [SqBits-1:0]         sq_x, sq_y, xy;
  logic [SqBits:0]           mag_sum, xy2;
  logic signed [SqBits:0]    re_full, re_shr;
  logic signed [SqBits+1:0]  im_full, im_shr;
  logic                      im_neg;
  logic signed [NBits-1:0]   nx, ny;
  logic [StepBits-1:0]       lim_n;
  logic                      chk, esc_prev, in_prev, out_rng;

  // Complex square of the current z
  assign mx      = MagBits'(zx_q[ZBits-1] ? -zx_q : zx_q);
  assign my      = MagBits'(zy_q[ZBits-1] ? -zy_q : zy_q);
  assign sq_x    = mx * mx;
  assign sq_y    = my * my;
  assign xy      = mx * my;
  assign mag_sum = sq_x + sq_y;

  // Real part: floor((x^2 - y^2) / 2^F) + cx
  assign re_full = $signed({1'b0, sq_x}) - $signed({1'b0, sq_y});
  assign re_shr  = re_full >>> mbc_pkg::FracBits;
  assign nx      = NBits'(re_shr) + NBits'(cx_q);

  // Imaginary part: floor(2xy / 2^F) + cy
  assign xy2     = {xy, 1'b0};
  assign im_neg  = (zx_q[ZBits-1] ^ zy_q[ZBits-1]) && (xy != '0);
  assign im_full = im_neg ? -$signed({1'b0, xy2}) : $signed({1'b0, xy2});
  assign im_shr  = im_full >>> mbc_pkg::FracBits;
  assign ny      = NBits'(im_shr) + NBits'(cy_q);

  // The radius test of the previous step uses this cycle's squares
  assign lim_n    = StepBits'(cfg_i.iter_limit) + StepBits'(1);
  assign chk      = (n_q != '0);
  assign esc_prev = chk && (mag_sum > EscTh);
  assign in_prev  = chk && (((n_q >= StepBits'(2)) && (zx_q == zpx_q) && (zy_q == zpy_q))
                            || (n_q > lim_n));
  assign out_rng  = (nx > ZLim) || (nx < -ZLim) || (ny > ZLim) || (ny < -ZLim);

  assign stat_o.iter_done = esc_prev || in_prev || out_rng;

  // Advance the orbit or record where it stopped
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_c) begin
      cx_q  <= cx_d;
      cy_q  <= cy_d;
      zx_q  <= '0;
      zy_q  <= '0;
      zpx_q <= '0;
      zpy_q <= '0;
      n_q   <= '0;
    end else if (cmd_i.iter) begin
      if (esc_prev || in_prev) begin
        fin_esc_q <= esc_prev;
        fin_n_q   <= n_q - StepBits'(1);
      end else if (out_rng) begin
        fin_esc_q <= 1'b1;
        fin_n_q   <= n_q;
      end else begin
        zpx_q <= zx_q;
        zpy_q <= zy_q;
        zx_q  <= ZBits'(nx);
        zy_q  <= ZBits'(ny);
        n_q   <= n_q + StepBits'(1);
      end
    end
  end

  // ---------------------------------------------------------------- colour
  logic [StepBits-1:0]         s, k;
  logic signed [LvlBits-1:0]   base_r, base_g, base_b;
  logic signed [SlopeBits-1:0] slp_r, slp_g, slp_b;
  logic signed [TBits-1:0]     t_r_q, t_g_q, t_b_q;

  // Pick the band and the step within it
  always_comb begin
    s      = fin_n_q;
    k      = s;
    base_r = LvlZero;  slp_r = SlpUp;
    base_g = LvlZero;  slp_g = SlpUp;
    base_b = LvlTop;   slp_b = SlpNone;
    if (s <= Bnd1) begin
      k = s;
    end else if ((s <= Bnd2) || ((s > Bnd4) && (s <= Bnd5)) || ((s > Bnd7) && (s <= Bnd8))) begin
      k      = (s <= Bnd2) ? (s - Bnd1) : ((s <= Bnd5) ? (s - Bnd4) : (s - Bnd7));
      base_r = LvlTop;  slp_r = SlpNone;
      base_g = LvlTop;  slp_g = SlpGreen;
      base_b = LvlTop;  slp_b = SlpDown;
    end else if ((s <= Bnd3) || (s > Bnd8)) begin
      k      = (s <= Bnd3) ? (s - Bnd2) : (s - Bnd8);
      base_r = LvlTop;   slp_r = SlpDown;
      base_g = LvlMid;   slp_g = SlpGreen;
      base_b = LvlZero;  slp_b = SlpUp;
    end else if ((s <= Bnd4) || ((s > Bnd6) && (s <= Bnd7))) begin
      k = (s <= Bnd4) ? (s - Bnd3) : (s - Bnd6);
    end else begin
      k      = s - Bnd5;
      base_r = LvlTop;   slp_r = SlpGreen;
      base_g = LvlMid;   slp_g = SlpHalf;
      base_b = LvlZero;  slp_b = SlpUp;
    end
  end

  // Hold band values in tenths; an inside pixel is black
  always_ff @(posedge clk_i) begin
    if (cmd_i.band) begin
      if (fin_esc_q) begin
        t_r_q <= band_t(base_r, slp_r, k);
        t_g_q <= band_t(base_g, slp_g, k);
        t_b_q <= band_t(base_b, slp_b, k);
      end else begin
        t_r_q <= '0;
        t_g_q <= '0;
        t_b_q <= '0;
      end
    end
  end

  // ---------------------------------------------------------------- output
  logic [ColBits-1:0]  red_q, green_q, blue_q;
  logic                escaped_q;
  logic [StepBits-1:0] iter_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      red_q     <= to_chan(t_r_q);
      green_q   <= to_chan(t_g_q);
      blue_q    <= to_chan(t_b_q);
      escaped_q <= fin_esc_q;
      iter_q    <= fin_n_q;
    end
  end

  assign red_o        = red_q;
  assign green_o      = green_q;
  assign blue_o       = blue_q;
  assign escaped_o    = escaped_q;
  assign iterations_o = iter_q;

  // The step counter never runs past the limit check
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.iter |-> (n_q <= lim_n + StepBits'(1)))
    else $error("orbit step counter past the limit");

  // A leaving coordinate records the current step as the escape point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.iter && out_rng && !esc_prev && !in_prev) |=>
      (fin_esc_q && (fin_n_q == $past(n_q))))
    else $error("escape step not recorded");

  // An inside pixel comes out black
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=>
      (escaped_q || ((red_q == '0) && (green_q == '0) && (blue_q == '0))))
    else $error("inside pixel not black");

endmodule
